FILE: rtl/lzsd_pkg.sv
// Package for the LZ stream decompressor: phase codes, status codes,
// signature table, channel payload types and the front-to-back request type.
// No dependencies.
package lzsd_pkg;

  localparam int HIST_BYTES = 65536;
  localparam int HIST_AW = $clog2(HIST_BYTES);
  localparam int POS_W = HIST_AW + 1;
  localparam int QDEPTH = 2;

  localparam logic [2:0] ST_BYTE = 3'd0;
  localparam logic [2:0] ST_ABSORB = 3'd1;
  localparam logic [2:0] ST_DONE = 3'd2;
  localparam logic [2:0] ST_NOTFMT = 3'd3;
  localparam logic [2:0] ST_UNSUP = 3'd4;
  localparam logic [2:0] ST_BADDIST = 3'd5;
  localparam logic [2:0] ST_TOOBIG = 3'd6;
  localparam logic [2:0] ST_IDLE = 3'd7;

  typedef enum logic [14:0] {
    PH_HDR    = 15'b000000000000001,
    PH_DSIZ   = 15'b000000000000010,
    PH_HED    = 15'b000000000000100,
    PH_SKIP   = 15'b000000000001000,
    PH_AUX    = 15'b000000000010000,
    PH_TOKEN  = 15'b000000000100000,
    PH_LITNUM = 15'b000000001000000,
    PH_MATNUM = 15'b000000010000000,
    PH_LIT    = 15'b000000100000000,
    PH_MDIST  = 15'b000001000000000,
    PH_MDISTX = 15'b000010000000000,
    PH_MLEN   = 15'b000100000000000,
    PH_COPY   = 15'b001000000000000,
    PH_DONE   = 15'b010000000000000,
    PH_ERR    = 15'b100000000000000
  } phase_t;

  // Payload of one input request
  typedef struct packed {
    logic       opcode;
    logic [7:0] in_byte;
    logic       in_last;
  } lz_in_t;

  // Payload of one result
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       out_last;
  } lz_out_t;

  // Kinds of request handed to the back end
  typedef enum logic [1:0] {
    RQ_STATUS = 2'd0,
    RQ_WRITE  = 2'd1,
    RQ_COPY   = 2'd2
  } rq_kind_t;

  typedef struct packed {
    rq_kind_t           kind;
    logic [7:0]         data;
    logic [2:0]         status;
    logic               last;
    logic [HIST_AW-1:0] wr_addr;
    logic [HIST_AW-1:0] rd_addr;
  } req_t;

  function automatic logic [7:0] sig_byte(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0, 4'd1, 4'd2: r = 8'hff;
      4'd3: r = 8'h01;
      4'd4, 4'd5, 4'd6: r = 8'h00;
      4'd7: r = 8'h4f;
      4'd8: r = 8'h53;
      4'd9: r = 8'h41;
      4'd10: r = 8'h53;
      4'd11: r = 8'h4b;
      4'd12: r = 8'h43;
      4'd13: r = 8'h4d;
      4'd14: r = 8'h50;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/lzsd_stream_if.sv
// Valid/ready stream interface with a generic payload type.
// Depends on lzsd_pkg for nothing but is compiled after it.
interface lzsd_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lzsd_front.sv
// Front end: parses header, numbers and tokens, tracks positions and
// issues write, copy or status requests. Depends on lzsd_pkg.
module lzsd_front import lzsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        rq_valid,
  input  logic        rq_ready,
  output req_t        rq
);

  phase_t      phase, phase_next;
  logic [3:0]  hidx, hidx_next;
  logic [31:0] acc, acc_next;
  logic [31:0] dsize, dsize_next;
  logic [POS_W-1:0] osize, osize_next, wpos, wpos_next;
  logic [POS_W-1:0] lit_rem, lit_rem_next, copy_rem, copy_rem_next;
  logic [POS_W-1:0] cdist, cdist_next;
  logic [31:0] mat_rem, mat_rem_next;
  logic        fbad, fbad_next;
  logic [2:0]  herr, herr_next;

  logic [31:0] acc_dig, v, dig_v;
  logic        dig_end;
  logic [31:0] lenv;
  logic [31:0] win;
  logic [POS_W-1:0] room;
  logic [POS_W-1:0] wpos_inc;
  logic        fire;

  assign in_ready = rq_ready;
  assign rq_valid = in_valid;
  assign fire = in_valid && rq_ready;
  assign acc_dig = {acc[24:0], 7'd0} | {24'd0, in_byte};
  assign dig_end = in_byte[0];
  assign dig_v = {1'b0, acc_dig[31:1]};
  assign v = dig_v;
  assign room = osize - wpos;
  assign wpos_inc = wpos + 1'b1;

  // Next phase and the request for this item
  always_comb begin
    logic        dist_done;
    logic [31:0] dist_acc;
    logic [31:0] len_in;
    logic        do_match;
    logic        emit;
    phase_next = phase; hidx_next = hidx; acc_next = acc; osize_next = osize;
    dsize_next = dsize;
    wpos_next = wpos; lit_rem_next = lit_rem; copy_rem_next = copy_rem;
    cdist_next = cdist; mat_rem_next = mat_rem; fbad_next = fbad; herr_next = herr;
    rq = '0;
    rq.kind = RQ_STATUS;
    rq.status = ST_ABSORB;
    dist_done = 1'b0; dist_acc = '0; len_in = '0; do_match = 1'b0; emit = 1'b0;
    win = '0; lenv = '0;
    priority if (phase == PH_DONE) begin
      rq.status = ST_DONE;
    end else if (phase == PH_ERR) begin
      rq.status = herr;
    end else if (opcode) begin
      if (phase != PH_COPY || copy_rem == '0) begin
        rq.status = ST_IDLE;
      end else begin
        rq.kind = RQ_COPY;
        rq.rd_addr = HIST_AW'(wpos - cdist);
        copy_rem_next = copy_rem - 1'b1;
        emit = 1'b1;
        if (wpos_inc < osize && copy_rem == POS_W'(1)) begin
          mat_rem_next = mat_rem - 1'b1;
          phase_next = (mat_rem != 32'd1) ? PH_MDIST : PH_TOKEN;
        end
      end
    end else if (phase == PH_LIT) begin
      rq.kind = RQ_WRITE;
      rq.data = in_byte;
      lit_rem_next = lit_rem - 1'b1;
      emit = 1'b1;
      if (wpos_inc < osize && lit_rem == POS_W'(1))
        phase_next = (mat_rem != '0) ? PH_MDIST : PH_TOKEN;
    end else begin
      unique case (phase)
        PH_HDR: begin
          if (hidx == 4'd0) fbad_next = (in_byte != 8'h83);
          if (hidx != 4'd0 && in_byte != sig_byte(hidx - 4'd1)) begin
            phase_next = PH_ERR; herr_next = ST_NOTFMT; rq.status = ST_NOTFMT;
          end else if (in_last) begin
            phase_next = PH_ERR; herr_next = ST_NOTFMT; rq.status = ST_NOTFMT;
          end else if (hidx == 4'd15) begin
            if (fbad) begin
              phase_next = PH_ERR; herr_next = ST_UNSUP; rq.status = ST_UNSUP;
            end else begin
              acc_next = '0; phase_next = PH_DSIZ;
            end
          end else begin
            hidx_next = hidx + 4'd1;
          end
        end
        PH_DSIZ: begin
          acc_next = acc_dig;
          if (dig_end) begin
            if (v == '0) begin
              phase_next = PH_DONE; rq.status = ST_DONE;
            end else begin
              // keep the full size until the flags have been checked
              dsize_next = v; acc_next = '0; phase_next = PH_HED;
            end
          end
        end
        PH_HED: begin
          acc_next = acc_dig;
          if (dig_end) begin
            win = 32'd1 << ({28'd0, v[4:1]} + 32'd8);
            if (dsize > win || v[5] || !v[0]) begin
              phase_next = PH_ERR; herr_next = ST_UNSUP; rq.status = ST_UNSUP;
            end else if (dsize > 32'(HIST_BYTES)) begin
              phase_next = PH_ERR; herr_next = ST_TOOBIG; rq.status = ST_TOOBIG;
            end else begin
              osize_next = dsize[POS_W-1:0];
              acc_next = '0; phase_next = v[6] ? PH_SKIP : PH_AUX;
            end
          end
        end
        PH_SKIP: begin
          acc_next = acc_dig;
          if (dig_end) begin acc_next = '0; phase_next = PH_AUX; end
        end
        PH_AUX: begin
          acc_next = acc_dig;
          if (dig_end) begin
            if (v != '0) begin
              phase_next = PH_ERR; herr_next = ST_UNSUP; rq.status = ST_UNSUP;
            end else begin
              wpos_next = '0; phase_next = PH_TOKEN;
            end
          end
        end
        PH_TOKEN: begin
          lit_rem_next = POS_W'(in_byte[3:0]);
          mat_rem_next = 32'(in_byte[7:4]);
          if (in_byte[3:0] == 4'd0) begin
            acc_next = '0; phase_next = PH_LITNUM;
          end else if (in_byte[7:4] == 4'd0) begin
            acc_next = '0; phase_next = PH_MATNUM;
          end else begin
            phase_next = PH_LIT;
          end
        end
        PH_LITNUM: begin
          acc_next = acc_dig;
          if (dig_end) begin
            lit_rem_next = (v > 32'(osize)) ? osize : POS_W'(v);
            if (mat_rem == '0) begin
              acc_next = '0; phase_next = PH_MATNUM;
            end else if (v != '0) phase_next = PH_LIT;
            else phase_next = PH_MDIST;
          end
        end
        PH_MATNUM: begin
          acc_next = acc_dig;
          if (dig_end) begin
            mat_rem_next = v;
            if (lit_rem != '0) phase_next = PH_LIT;
            else phase_next = (v != '0) ? PH_MDIST : PH_TOKEN;
          end
        end
        PH_MDIST: begin
          copy_rem_next = POS_W'(in_byte[7:4]);
          acc_next = {28'd0, in_byte[3:0]};
          if (!in_byte[0]) phase_next = PH_MDISTX;
          else begin dist_done = 1'b1; dist_acc = {28'd0, in_byte[3:0]}; end
        end
        PH_MDISTX: begin
          acc_next = acc_dig;
          if (dig_end) begin dist_done = 1'b1; dist_acc = acc_dig; end
        end
        PH_MLEN: begin
          acc_next = acc_dig;
          if (dig_end) begin do_match = 1'b1; len_in = v + 32'd1; end
        end
        default: rq.status = ST_IDLE;
      endcase
    end

    // Distance complete: either a length number follows or the match starts, unless the distance is bad
    if (dist_done) begin
      logic [31:0] d;
      d = {1'b0, dist_acc[31:1]} + 32'd1;
      cdist_next = (d > 32'(HIST_BYTES) + 32'd1) ? '1 : POS_W'(d);
      if (copy_rem_next == '0) begin
        acc_next = '0; phase_next = PH_MLEN;
      end else begin
        do_match = 1'b1; len_in = 32'(copy_rem_next) + 32'd1;
        if (d > 32'(wpos) || d == '0) begin
          phase_next = PH_ERR; herr_next = ST_BADDIST; rq.status = ST_BADDIST;
          do_match = 1'b0;
        end
      end
    end
    if (do_match) begin
      if (phase == PH_MLEN && (32'(cdist) > 32'(wpos) || cdist == '0)) begin
        phase_next = PH_ERR; herr_next = ST_BADDIST; rq.status = ST_BADDIST;
      end else begin
        lenv = len_in;
        copy_rem_next = (lenv == '0 || lenv > 32'(room)) ? room : POS_W'(lenv);
        phase_next = PH_COPY;
      end
    end
    if (emit) begin
      rq.wr_addr = HIST_AW'(wpos);
      rq.status = ST_BYTE;
      wpos_next = wpos_inc;
      if (wpos_inc >= osize) begin
        rq.last = 1'b1; phase_next = PH_DONE;
      end
    end
  end

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR; hidx <= '0; acc <= '0; osize <= '0; wpos <= '0;
      lit_rem <= '0; copy_rem <= '0; cdist <= '0; mat_rem <= '0;
      fbad <= 1'b0; herr <= '0; dsize <= '0;
    end else if (fire) begin
      phase <= phase_next; hidx <= hidx_next; acc <= acc_next;
      osize <= osize_next; wpos <= wpos_next; lit_rem <= lit_rem_next;
      copy_rem <= copy_rem_next; cdist <= cdist_next; mat_rem <= mat_rem_next;
      fbad <= fbad_next; herr <= herr_next; dsize <= dsize_next;
    end
  end

endmodule

FILE: rtl/lzsd_queue.sv
// Short request queue between front and back end.
// Depends on lzsd_pkg.
module lzsd_queue import lzsd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output req_t out_req
);
  localparam int CW = $clog2(QDEPTH + 1);
  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  req_t mem [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic push, pop;

  assign in_ready = (cnt != CW'(QDEPTH));
  assign out_valid = (cnt != '0);
  assign out_req = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Store on push
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_req;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop) rp <= (rp == PW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      unique case ({push, pop})
        2'b10: cnt <= cnt + 1'b1;
        2'b01: cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end
endmodule

FILE: rtl/lzsd_back.sv
// Back end: carries out write and copy requests against the history
// memory and registers the result. Depends on lzsd_pkg.
module lzsd_back import lzsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rq_valid,
  output logic       rq_ready,
  input  req_t       rq,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       out_last
);
  logic [7:0] hist [HIST_BYTES];
  logic [7:0] rd_data;
  logic       s1_valid;
  req_t       s1;
  logic       take;
  logic [7:0] s1_byte;
  logic       fwd;
  logic [HIST_AW-1:0] prev_addr;
  logic [7:0] prev_data;
  logic       prev_ok;

  // Each request reads in stage 1, then writes and presents its result in stage 2
  assign rq_ready = !s1_valid && (!out_valid || out_ready);
  assign take = rq_valid && rq_ready;
  assign fwd = prev_ok && prev_addr == s1.rd_addr;
  assign s1_byte = (s1.kind == RQ_COPY) ? (fwd ? prev_data : rd_data) : s1.data;

  // Read and write the history memory
  always_ff @(posedge clk) begin
    if (take) rd_data <= hist[rq.rd_addr];
    if (s1_valid && s1.kind != RQ_STATUS) hist[s1.wr_addr] <= s1_byte;
  end

  // Track stage 1, the output valid and the last written byte for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0; out_valid <= 1'b0; prev_ok <= 1'b0;
    end else begin
      if (take) begin s1_valid <= 1'b1; s1 <= rq; end
      else if (s1_valid) s1_valid <= 1'b0;
      if (s1_valid) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (s1_valid && s1.kind != RQ_STATUS) begin
        prev_ok <= 1'b1; prev_addr <= s1.wr_addr; prev_data <= s1_byte;
      end
    end
  end

  // Hold the result
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      out_byte <= (s1.kind == RQ_STATUS) ? 8'd0 : s1_byte;
      status <= s1.status;
      out_last <= s1.last;
    end
  end
endmodule

FILE: rtl/lz_stream_decompressor.sv
// LZ stream decompressor: one compressed byte or advance request per item,
// one result per item. Requests pass through the front end, the request queue
// and the back end; the back end takes no new request while the previous one is
// still between its read and its write, due to the read-then-write use of the
// single history memory port. Synchronous active-high reset clears parser state
// and queue, not the history memory.
module lz_stream_decompressor import lzsd_pkg::*; (
  input logic clk,
  input logic rst,
  lzsd_stream_if.sink   in_ch,
  lzsd_stream_if.source out_ch
);
  logic f_valid, f_ready, b_valid, b_ready;
  req_t f_req, b_req;
  logic [7:0] ob;
  logic [2:0] os;
  logic ol;

  lzsd_front u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .opcode(in_ch.data.opcode), .in_byte(in_ch.data.in_byte),
    .in_last(in_ch.data.in_last),
    .rq_valid(f_valid), .rq_ready(f_ready), .rq(f_req)
  );

  lzsd_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(f_ready), .in_req(f_req),
    .out_valid(b_valid), .out_ready(b_ready), .out_req(b_req)
  );

  lzsd_back u_back (
    .clk, .rst, .rq_valid(b_valid), .rq_ready(b_ready), .rq(b_req),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_byte(ob), .status(os), .out_last(ol)
  );

  assign out_ch.data.out_byte = ob;
  assign out_ch.data.status = os;
  assign out_ch.data.out_last = ol;
endmodule

FILE: sim/tb_lz_stream_decompressor.sv
// Testbench for lz_stream_decompressor: one well-formed compressed file is fed
// through valid/ready channels and every result is checked against a predictor.
// Depends on lzsd_pkg, lzsd_stream_if and the decompressor RTL.
`timescale 1ns / 1ps

module tb_lz_stream_decompressor;
  import lzsd_pkg::*;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  lzsd_stream_if #(.T(lz_in_t)) in_ch (clk);
  lzsd_stream_if #(.T(lz_out_t)) out_ch (clk);

  lz_stream_decompressor uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Predictor state
  logic [7:0]  hist_mem [0:HIST_BYTES-1];
  phase_t      p_phase;
  logic [31:0] p_hdr_idx;
  logic [31:0] p_acc;
  logic [31:0] p_size;
  logic [31:0] p_wp;
  logic [31:0] p_lit_left;
  logic [31:0] p_match_left;
  logic [31:0] p_copy_left;
  logic [31:0] p_dist;
  logic        p_first_bad;
  logic [2:0]  p_err;

  lz_out_t decoded_q[$];
  int errors = 0;
  int idle_cnt = 0;
  bit hold_req = 0;
  bit no_gaps = 0;

  logic [7:0] sig_tab [0:14] = '{8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 8'h00,
                                 8'h4f, 8'h53, 8'h41, 8'h53, 8'h4b, 8'h43, 8'h4d,
                                 8'h50};

  function automatic bit take_digit(input logic [7:0] b);
    p_acc = (p_acc << 7) | {24'd0, b};
    return b[0];
  endfunction

  function automatic logic [2:0] fail_with(input logic [2:0] code);
    p_phase = PH_ERR;
    p_err = code;
    return code;
  endfunction

  function automatic void after_lits();
    p_phase = (p_match_left != 0) ? PH_MDIST : PH_TOKEN;
  endfunction

  function automatic void start_lits();
    if (p_lit_left != 0) p_phase = PH_LIT;
    else after_lits();
  endfunction

  function automatic void start_num(input phase_t nxt);
    p_acc = 0;
    p_phase = nxt;
  endfunction

  function automatic logic [2:0] finish_match(input logic [31:0] len);
    logic [31:0] room;
    if (p_dist > p_wp || p_dist == 0) return fail_with(ST_BADDIST);
    room = p_size - p_wp;
    p_copy_left = (len == 0 || len > room) ? room : len;
    p_phase = PH_COPY;
    return ST_ABSORB;
  endfunction

  function automatic logic [2:0] parse_byte(input logic [7:0] b, input logic last);
    logic [31:0] v;
    bit dist_ready;
    dist_ready = 0;
    case (p_phase)
      PH_HDR: begin
        if (p_hdr_idx == 0) p_first_bad = (b != 8'h83);
        else if (b != sig_tab[(p_hdr_idx - 1) & 15] || p_hdr_idx > 15)
          return fail_with(ST_NOTFMT);
        if (last) return fail_with(ST_NOTFMT);
        if (p_hdr_idx >= 15) begin
          if (p_first_bad) return fail_with(ST_UNSUP);
          start_num(PH_DSIZ);
          return ST_ABSORB;
        end
        p_hdr_idx++;
        return ST_ABSORB;
      end
      PH_DSIZ: begin
        if (!take_digit(b)) return ST_ABSORB;
        v = p_acc >> 1;
        if (v == 0) begin
          p_phase = PH_DONE;
          return ST_DONE;
        end
        p_size = v;
        start_num(PH_HED);
        return ST_ABSORB;
      end
      PH_HED: begin
        if (!take_digit(b)) return ST_ABSORB;
        v = p_acc >> 1;
        if (p_size > (32'd1 << (((v >> 1) & 32'h0f) + 8)) || (v & 32'h21) != 32'h01)
          return fail_with(ST_UNSUP);
        if (p_size > HIST_BYTES) return fail_with(ST_TOOBIG);
        start_num(v[6] ? PH_SKIP : PH_AUX);
        return ST_ABSORB;
      end
      PH_SKIP: begin
        if (take_digit(b)) start_num(PH_AUX);
        return ST_ABSORB;
      end
      PH_AUX: begin
        if (!take_digit(b)) return ST_ABSORB;
        if ((p_acc >> 1) != 0) return fail_with(ST_UNSUP);
        p_wp = 0;
        p_phase = PH_TOKEN;
        return ST_ABSORB;
      end
      PH_TOKEN: begin
        p_lit_left = {28'd0, b[3:0]};
        p_match_left = {28'd0, b[7:4]};
        if (p_lit_left == 0) start_num(PH_LITNUM);
        else if (p_match_left == 0) start_num(PH_MATNUM);
        else start_lits();
        return ST_ABSORB;
      end
      PH_LITNUM: begin
        if (!take_digit(b)) return ST_ABSORB;
        p_lit_left = p_acc >> 1;
        if (p_match_left == 0) start_num(PH_MATNUM);
        else start_lits();
        return ST_ABSORB;
      end
      PH_MATNUM: begin
        if (!take_digit(b)) return ST_ABSORB;
        p_match_left = p_acc >> 1;
        start_lits();
        return ST_ABSORB;
      end
      PH_MDIST: begin
        p_copy_left = {28'd0, b[7:4]};
        p_acc = {28'd0, b[3:0]};
        if (!b[0]) begin
          p_phase = PH_MDISTX;
          return ST_ABSORB;
        end
        dist_ready = 1;
      end
      PH_MDISTX: begin
        if (!take_digit(b)) return ST_ABSORB;
        dist_ready = 1;
      end
      PH_MLEN: begin
        if (!take_digit(b)) return ST_ABSORB;
        return finish_match((p_acc >> 1) + 1);
      end
      default: return ST_IDLE;
    endcase
    // distance is complete here
    p_dist = (p_acc >> 1) + 1;
    if (p_copy_left == 0) begin
      start_num(PH_MLEN);
      return ST_ABSORB;
    end
    return finish_match(p_copy_left + 1);
  endfunction

  function automatic lz_out_t emit_byte(input logic [7:0] b);
    lz_out_t r;
    if (p_wp < HIST_BYTES) hist_mem[p_wp[HIST_AW-1:0]] = b;
    p_wp++;
    r.out_byte = b;
    r.status = ST_BYTE;
    r.out_last = 1'b0;
    if (p_wp >= p_size) begin
      p_phase = PH_DONE;
      r.out_last = 1'b1;
    end
    return r;
  endfunction

  // Work out the result of one accepted request
  function automatic lz_out_t decode_step(input lz_in_t rq);
    lz_out_t r;
    logic [31:0] src;
    logic [7:0] v;
    r = '0;
    if (p_phase == PH_DONE) begin
      r.status = ST_DONE;
      return r;
    end
    if (p_phase == PH_ERR) begin
      r.status = p_err;
      return r;
    end
    if (rq.opcode == OP_ADVANCE) begin
      if (p_phase != PH_COPY || p_copy_left == 0) begin
        r.status = ST_IDLE;
        return r;
      end
      src = p_wp - p_dist;
      v = (src < HIST_BYTES) ? hist_mem[src[HIST_AW-1:0]] : 8'h00;
      p_copy_left--;
      r = emit_byte(v);
      if (p_phase != PH_DONE && p_copy_left == 0) begin
        p_match_left--;
        p_phase = (p_match_left != 0) ? PH_MDIST : PH_TOKEN;
      end
      return r;
    end
    if (p_phase == PH_LIT) begin
      p_lit_left--;
      r = emit_byte(rq.in_byte);
      if (p_phase != PH_DONE && p_lit_left == 0) after_lits();
      return r;
    end
    r.status = parse_byte(rq.in_byte, rq.in_last);
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one request, with a random gap before it unless no_gaps is set
  task automatic send_item(input logic op, input logic [7:0] b, input logic last);
    int gap;
    lz_in_t rq;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rq.opcode = op;
    rq.in_byte = b;
    rq.in_last = last;
    in_ch.data <= rq;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    decoded_q.push_back(decode_step(rq));
    @(negedge clk);
  endtask

  task automatic feed(input logic [7:0] b);
    send_item(OP_FEED, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic pull_copy();
    while (p_phase == PH_COPY) begin
      if ($urandom_range(0, 7) == 0) feed(8'($urandom));
      else send_item(OP_ADVANCE, 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // Small count as a one- or two-digit number
  task automatic send_count(input int c);
    if ($urandom_range(0, 3) == 0) feed(8'h00);
    feed(8'((c << 1) | 1));
  endtask

  task automatic test_header();
    send_item(OP_FEED, 8'h83, 1'b0);
    for (int i = 0; i < 15; i++) send_item(OP_FEED, sig_tab[i], 1'b0);
  endtask

  task automatic test_preamble();
    // size 1300, window 2048 with skip flag, two-digit skip, aux zero
    feed(8'h14);
    feed(8'h29);
    feed(8'h8f);
    feed(8'h06);
    feed(8'h8d);
    feed(8'h01);
  endtask

  task automatic test_directed_runs();
    send_item(OP_ADVANCE, 8'h00, 1'b0);
    feed(8'h23);
    feed(8'h00);
    feed(8'hff);
    feed(8'h80);
    // distance one, length from a number
    feed(8'h01);
    feed(8'h05);
    send_item(OP_ADVANCE, 8'hff, 1'b1);
    feed(8'h55);
    pull_copy();
    feed(8'h23);
    pull_copy();
    // zero nibbles: both counts as numbers, no literals
    feed(8'h00);
    feed(8'h01);
    feed(8'h03);
    // extended distance
    feed(8'h10);
    feed(8'h07);
    pull_copy();
    feed(8'h01);
    feed(8'h01);
    feed(8'hc3);
  endtask

  task automatic test_random_runs();
    int d;
    int h;
    int lim;
    hold_req = 1;
    while (p_phase != PH_DONE && p_phase != PH_ERR) begin
      if ($urandom_range(0, 99) == 0) no_gaps = !no_gaps;
      case (p_phase)
        PH_TOKEN: begin
          if ($urandom_range(0, 15) == 0) send_item(OP_ADVANCE, 8'($urandom), 1'b1);
          else feed({4'($urandom_range(0, 3)), 4'($urandom)});
        end
        PH_LITNUM, PH_MATNUM: send_count($urandom_range(0, 12));
        PH_LIT: feed(8'($urandom));
        PH_MDIST: begin
          h = $urandom_range(0, 15);
          lim = (p_wp > 960) ? 960 : p_wp;
          d = $urandom_range(1, lim);
          if (d <= 8 && $urandom_range(0, 1)) begin
            feed(8'((h << 4) | ((d - 1) << 1) | 1));
          end else begin
            if (((d - 1) >> 6) & 1) d = (d - 1) & ~63;
            feed(8'((h << 4) | ((d - 1) >> 6)));
            feed(8'((((d - 1) & 63) << 1) | 1));
          end
        end
        PH_MLEN: feed(8'($urandom | 1));
        PH_COPY: pull_copy();
        default: feed(8'($urandom));
      endcase
    end
    no_gaps = 0;
  endtask

  task automatic test_finished();
    repeat (4) send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
      n = no_gaps ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    lz_out_t got;
    lz_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (decoded_q.size() == 0) begin
        report("unexpected result", got, 0);
      end else begin
        want = decoded_q.pop_front();
        if (got.status !== want.status) report("status", got.status, want.status);
        if (got.out_byte !== want.out_byte) report("out_byte", got.out_byte, want.out_byte);
        if (got.out_last !== want.out_last) report("out_last", got.out_last, want.out_last);
      end
    end
  end

  // Watchdog on cycles without any accepted request or accepted result
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results pending", decoded_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    p_phase = PH_HDR;
    p_hdr_idx = 0;
    p_acc = 0;
    p_size = 0;
    p_wp = 0;
    p_lit_left = 0;
    p_match_left = 0;
    p_copy_left = 0;
    p_dist = 0;
    p_first_bad = 0;
    p_err = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_header();
    test_preamble();
    test_directed_runs();
    test_random_runs();
    test_finished();
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
